FILE: rtl/core/mst_pkg.sv
`timescale 1ns / 1ps
package mst_pkg;
  localparam logic [2:0] REQ_CONFIG  = 3'd0;
  localparam logic [2:0] REQ_START   = 3'd1;
  localparam logic [2:0] REQ_STOP    = 3'd2;
  localparam logic [2:0] REQ_RESTART = 3'd3;
  localparam logic [2:0] REQ_QUERY   = 3'd4;
  localparam logic [2:0] REQ_TICK    = 3'd5;

  localparam logic [1:0] EV_ACK  = 2'd0;
  localparam logic [1:0] EV_EXP  = 2'd1;
  localparam logic [1:0] EV_NONE = 2'd2;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_EXP  = 2'd2;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [2:0]  slot;
    logic [30:0] period;
    logic        reload;
  } mst_in_t;

  typedef struct packed {
    logic [2:0] slot_out;
    logic [1:0] event_res;
    logic       running;
    logic       last;
  } mst_out_t;
endpackage

FILE: rtl/core/mst_slot_mem.sv
`timescale 1ns / 1ps
module mst_slot_mem #(
  parameter int NUM_SLOTS = 8,
  parameter int TIME_BITS = 32,
  parameter int AW = 3
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [TIME_BITS+33:0] wdata,
  input  logic [AW-1:0]        raddr,
  output logic [TIME_BITS+33:0] rdata
);
  // entry: expiry, period, reload, status
  logic [TIME_BITS+33:0] mem [NUM_SLOTS];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/core/multi_slot_one_shot_periodic_timer.sv
`timescale 1ns / 1ps
// Timer bank whose slot state sits in a single-port-read memory. A slot request
// passes through a read state and an execute state (clear pass aside); a tick
// walks every slot, one memory read per slot and a write-back for each due slot,
// then flushes; it puts out at most one result a cycle. Results appear with done
// high for one cycle each and cannot be stalled. A clear pass after reset keeps busy high.
module multi_slot_one_shot_periodic_timer #(
  parameter int NUM_SLOTS = 8,
  parameter int TIME_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  mst_pkg::mst_in_t    req,
  output logic                busy,
  output logic                done,
  output mst_pkg::mst_out_t   result
);
  import mst_pkg::*;

  localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam int EW = TIME_BITS + 34;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_TREAD = 3'd4;
  localparam logic [2:0] S_TEXEC = 3'd5;
  localparam logic [2:0] S_FLUSH = 3'd6;

  logic [2:0]           state;
  logic [CW-1:0]        idx;
  logic [TIME_BITS-1:0] now;
  mst_in_t              cur;
  logic                 pend_v;
  mst_out_t             pend;

  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  logic [EW-1:0]        wdata, rdata;

  mst_slot_mem #(.NUM_SLOTS(NUM_SLOTS), .TIME_BITS(TIME_BITS), .AW(AW)) u_mem (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  logic [TIME_BITS-1:0] r_exp;
  logic [30:0]          r_per;
  logic                 r_rl;
  logic [1:0]           r_st;
  assign r_exp = rdata[EW-1 -: TIME_BITS];
  assign r_per = rdata[33:3];
  assign r_rl  = rdata[2];
  assign r_st  = rdata[1:0];

  logic [TIME_BITS-1:0] per_t, arm_exp, diff, adv_exp;
  logic                 in_bank, due;
  assign per_t   = TIME_BITS'(r_per);
  assign arm_exp = now + per_t;
  assign adv_exp = r_exp + per_t;
  assign diff    = now - r_exp;
  assign due     = (r_st == ST_RUN) && !diff[TIME_BITS-1];
  assign in_bank = 32'(cur.slot) < NUM_SLOTS;

  assign busy = (state != S_IDLE);

  logic [1:0]  st_new;
  logic [30:0] per_new;
  always_comb begin
    we = 1'b0;
    waddr = idx[AW-1:0];
    wdata = rdata;
    raddr = idx[AW-1:0];
    st_new = r_st;
    per_new = (cur.period == '0) ? 31'd1 : cur.period;
    unique case (state)
      S_CLEAR: begin
        we = 1'b1;
        wdata = {{TIME_BITS{1'b0}}, 31'd1, 1'b0, ST_IDLE};
      end
      S_READ:  raddr = AW'(cur.slot);
      S_EXEC: begin
        waddr = AW'(cur.slot);
        case (cur.req_type)
          REQ_CONFIG: begin
            we = in_bank;
            wdata = {r_exp, per_new, cur.reload, ST_IDLE};
          end
          REQ_START, REQ_RESTART: begin
            we = in_bank;
            wdata = {arm_exp, r_per, r_rl, ST_RUN};
          end
          REQ_STOP: begin
            we = in_bank;
            if (r_st == ST_RUN) st_new = ST_IDLE;
            wdata = {r_exp, r_per, r_rl, st_new};
          end
          default: ;
        endcase
      end
      S_TEXEC: begin
        we = due;
        waddr = idx[AW-1:0];
        wdata = r_rl ? {adv_exp, r_per, r_rl, r_st} : {r_exp, r_per, r_rl, ST_EXP};
        raddr = AW'(idx + CW'(1));
      end
      default: ;
    endcase
  end

  logic run_ack;
  always_comb begin
    run_ack = 1'b0;
    if (in_bank) begin
      case (cur.req_type)
        REQ_CONFIG: run_ack = 1'b0;
        REQ_STOP: run_ack = 1'b0;
        REQ_START, REQ_RESTART: run_ack = 1'b1;
        default: run_ack = (r_st == ST_RUN);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx <= '0;
      now <= '0;
      done <= 1'b0;
      pend_v <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          idx <= idx + CW'(1);
          if (idx == CW'(NUM_SLOTS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            cur <= req;
            if (req.req_type == REQ_TICK) begin
              now <= now + TIME_BITS'(1);
              idx <= '0;
              pend_v <= 1'b0;
              state <= S_TREAD;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: state <= S_EXEC;
        S_EXEC: begin
          done <= 1'b1;
          result <= '{slot_out: cur.slot, event_res: EV_ACK, running: run_ack, last: 1'b1};
          state <= S_IDLE;
        end
        S_TREAD: state <= S_TEXEC;
        S_TEXEC: begin
          // hold each expiry back until the next is found, so the final one can carry last
          if (due) begin
            pend_v <= 1'b1;
            pend <= '{slot_out: 3'(idx), event_res: EV_EXP, running: r_rl, last: 1'b0};
            if (pend_v) begin
              done <= 1'b1;
              result <= pend;
            end
          end
          idx <= idx + CW'(1);
          if (idx == CW'(NUM_SLOTS - 1)) state <= S_FLUSH;
        end
        S_FLUSH: begin
          // flush the final held expiry or report nothing due
          done <= 1'b1;
          if (pend_v) result <= '{slot_out: pend.slot_out, event_res: EV_EXP,
                                  running: pend.running, last: 1'b1};
          else result <= '{slot_out: 3'd0, event_res: EV_NONE, running: 1'b0, last: 1'b1};
          pend_v <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import mst_pkg::*;

  localparam int NSLOT = 8;

  class timer_scoreboard;
    logic [31:0] now_q;
    logic [31:0] due_at[NSLOT];
    logic [30:0] per_q[NSLOT];
    logic        autoload[NSLOT];
    logic [1:0]  status[NSLOT];
    mst_out_t    pending[$];
    int          errors;

    function void clear();
      now_q = '0;
      for (int i = 0; i < NSLOT; i++) begin
        due_at[i] = '0;
        per_q[i] = 31'd1;
        autoload[i] = 1'b0;
        status[i] = ST_IDLE;
      end
      pending.delete();
      errors = 0;
    endfunction

    function void note_request(mst_in_t r);
      mst_out_t o;
      logic [31:0] diff;
      int n;
      n = 0;
      if (r.req_type == REQ_TICK) begin
        now_q = now_q + 32'd1;
        for (int i = 0; i < NSLOT; i++) begin
          diff = now_q - due_at[i];
          if (status[i] == ST_RUN && !diff[31]) begin
            if (autoload[i]) due_at[i] = due_at[i] + {1'b0, per_q[i]};
            else status[i] = ST_EXP;
            o.slot_out = i[2:0];
            o.event_res = EV_EXP;
            o.running = autoload[i];
            o.last = 1'b0;
            pending.push_back(o);
            n++;
          end
        end
        if (n == 0) begin
          o = '{slot_out: 3'd0, event_res: EV_NONE, running: 1'b0, last: 1'b1};
          pending.push_back(o);
        end else begin
          pending[$].last = 1'b1;
        end
        return;
      end
      case (r.req_type)
        REQ_CONFIG: begin
          per_q[r.slot] = (r.period == '0) ? 31'd1 : r.period;
          autoload[r.slot] = r.reload;
          status[r.slot] = ST_IDLE;
        end
        REQ_START, REQ_RESTART: begin
          due_at[r.slot] = now_q + {1'b0, per_q[r.slot]};
          status[r.slot] = ST_RUN;
        end
        REQ_STOP: if (status[r.slot] == ST_RUN) status[r.slot] = ST_IDLE;
        default: ;
      endcase
      o.slot_out = r.slot;
      o.event_res = EV_ACK;
      o.running = (status[r.slot] == ST_RUN);
      o.last = 1'b1;
      pending.push_back(o);
    endfunction

    function void check_result(mst_out_t got);
      mst_out_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  mst_in_t  req = '0;
  logic     busy, done;
  mst_out_t result;

  timer_scoreboard sb;
  int gap_pct;

  multi_slot_one_shot_periodic_timer dut (
    .clk(clk), .rst(rst), .start(start), .req(req),
    .busy(busy), .done(done), .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) if (!rst && done) sb.check_result(result);

  // start is raised at a falling edge and held until an edge sees busy low
  task automatic send(mst_in_t r);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    req <= r;
    start <= 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_request(r);
    @(negedge clk);
  endtask

  task automatic send_req(logic [2:0] op, logic [2:0] s, logic [30:0] p, logic rl);
    mst_in_t r;
    r.req_type = op;
    r.slot = s;
    r.period = p;
    r.reload = rl;
    send(r);
  endtask

  function automatic logic [30:0] pick_period();
    case ($urandom_range(9))
      0: return 31'd0;
      1: return 31'h7fffffff;
      2: return 31'($urandom());
      default: return 31'($urandom_range(6, 1));
    endcase
  endfunction

  task automatic random_req();
    int k;
    logic [2:0] s;
    k = $urandom_range(99);
    s = 3'($urandom_range(7));
    if (k < 40) send_req(REQ_TICK, 3'($urandom()), 31'($urandom()), 1'($urandom()));
    else if (k < 55) send_req(REQ_CONFIG, s, pick_period(), 1'($urandom()));
    else if (k < 72) send_req(REQ_START, s, 31'($urandom()), 1'($urandom()));
    else if (k < 80) send_req(REQ_RESTART, s, 31'($urandom()), 1'($urandom()));
    else if (k < 88) send_req(REQ_STOP, s, 31'($urandom()), 1'($urandom()));
    else if (k < 96) send_req(REQ_QUERY, s, 31'($urandom()), 1'($urandom()));
    else send_req(3'($urandom_range(7, 6)), s, 31'($urandom()), 1'($urandom()));
  endtask

  initial begin
    sb = new();
    sb.clear();
    gap_pct = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_req(REQ_TICK, 3'd0, 31'd0, 1'b0);
    send_req(REQ_QUERY, 3'd3, 31'd0, 1'b0);
    send_req(REQ_CONFIG, 3'd0, 31'd0, 1'b1);
    send_req(REQ_CONFIG, 3'd7, 31'h7fffffff, 1'b0);
    send_req(REQ_CONFIG, 3'd2, 31'd2, 1'b0);
    send_req(REQ_START, 3'd0, 31'd0, 1'b0);
    send_req(REQ_START, 3'd7, 31'd0, 1'b0);
    send_req(REQ_RESTART, 3'd2, 31'h7fffffff, 1'b1);
    send_req(REQ_START, 3'd5, 31'd0, 1'b0);
    send_req(REQ_TICK, 3'd7, 31'h7fffffff, 1'b1);
    send_req(REQ_TICK, 3'd0, 31'd0, 1'b0);
    send_req(REQ_TICK, 3'd0, 31'd0, 1'b0);
    send_req(REQ_QUERY, 3'd2, 31'd0, 1'b0);
    send_req(REQ_STOP, 3'd0, 31'd0, 1'b0);
    send_req(REQ_STOP, 3'd2, 31'd0, 1'b0);
    send_req(3'd6, 3'd1, 31'd5, 1'b1);
    send_req(3'd7, 3'd6, 31'd5, 1'b0);
    // every slot periodic with period 1, so one tick fires all of them
    for (int i = 0; i < NSLOT; i++) begin
      send_req(REQ_CONFIG, i[2:0], 31'd1, 1'b1);
      send_req(REQ_START, i[2:0], 31'd0, 1'b0);
    end
    send_req(REQ_TICK, 3'd0, 31'd0, 1'b0);
    for (int ph = 0; ph < 3; ph++) begin
      gap_pct = (ph == 0) ? 21 : (ph == 1) ? 80 : 0;
      repeat (100) random_req();
    end
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end
endmodule
